/* rtl/core/ebid_pkg.sv */
// Shared types and constants for the eight button integrating debouncer.
`default_nettype none

package ebid_pkg;

  localparam int NumButtons = 8;
  localparam int IdxW       = 3;
  localparam int CntW       = 8;

  localparam logic [CntW-1:0] DEBOUNCE_RESET = 8'd5;

  typedef enum logic [1:0] {
    OP_SET       = 2'd0,
    OP_TICK      = 2'd1,
    OP_CLR_PRESS = 2'd2,
    OP_CLR_REL   = 2'd3
  } op_e;

  typedef struct packed {
    op_e             op;
    logic [IdxW-1:0] idx;
    logic            level;
  } item_t;

  typedef struct packed {
    logic [NumButtons-1:0] levels;
    logic [NumButtons-1:0] pressed;
    logic [NumButtons-1:0] released;
  } res_t;

endpackage

`default_nettype wire

/* rtl/core/eight_button_integrating_debouncer.sv */
// Top level of the eight button integrating debouncer.
//
// Input channel: in_valid_i / in_stall_o with op_i, button_index_i and
// raw_level_i. An item is taken at a clock edge with valid high, stall low.
// Ops: set one button's raw level, tick all integrators, clear one pressed
// flag, clear one released flag.
// Output channel: out_valid_o / out_stall_i; every item yields one result
// with the debounced levels and both sticky flag vectors after that item.
// Each item passes through the input register, then the result register.
// One item per cycle is sustained while out_stall_i is low; each item is a
// single pass through the eight integrator lanes.
// cfg_we_i / cfg_wdata_i write the debounce period in ticks (reset 5).
// Reset clears all integrators, levels, flags and both valid bits.
// While out_stall_i holds a result, the input register still fills; once
// it is full, in_stall_o rises until the result is taken.
`default_nettype none

module eight_button_integrating_debouncer
  import ebid_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [1:0]            op_i,
  input  logic [IdxW-1:0]       button_index_i,
  input  logic                  raw_level_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [NumButtons-1:0] debounced_levels_o,
  output logic [NumButtons-1:0] pressed_flags_o,
  output logic [NumButtons-1:0] released_flags_o,
  input  logic                  cfg_we_i,
  input  logic [CntW-1:0]       cfg_wdata_i
);

  logic            in_valid_q;
  item_t           item_q;
  logic            out_valid_q;
  res_t            res_q, res_d;
  logic [CntW-1:0] ticks_q;
  logic            res_ready;
  logic            step;

  assign res_ready  = !out_valid_q || !out_stall_i;
  assign step       = in_valid_q && res_ready;
  assign in_stall_o = in_valid_q && !res_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ticks_q <= DEBOUNCE_RESET;
    end else if (cfg_we_i) begin
      ticks_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (!in_stall_o) begin
        in_valid_q <= in_valid_i;
      end
      if (res_ready) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      item_q.op    <= op_e'(op_i);
      item_q.idx   <= button_index_i;
      item_q.level <= raw_level_i;
    end
    if (step) begin
      res_q <= res_d;
    end
  end

  ebid_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (step),
    .item_i  (item_q),
    .ticks_i (ticks_q),
    .res_o   (res_d)
  );

  assign out_valid_o        = out_valid_q;
  assign debounced_levels_o = res_q.levels;
  assign pressed_flags_o    = res_q.pressed;
  assign released_flags_o   = res_q.released;

endmodule

`default_nettype wire

/* rtl/core/ebid_lane.sv */
// One button's saturating integrator and debounced level.
`default_nettype none

module ebid_lane
  import ebid_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            tick_i,
  input  logic            raw_i,
  input  logic [CntW-1:0] ticks_i,
  output logic            level_o,
  output logic            level_next_o
);

  logic [CntW-1:0] integ_q, integ_d;
  logic            level_q, level_d;

  always_comb begin
    integ_d = integ_q;
    level_d = level_q;
    if (tick_i) begin
      if (raw_i) begin
        if (integ_q < ticks_i) begin
          integ_d = integ_q + CntW'(1);
        end else begin
          integ_d = ticks_i;
        end
      end else if (integ_q != '0) begin
        integ_d = integ_q - CntW'(1);
      end
      if (integ_d == '0) begin
        level_d = 1'b0;
      end else if (integ_d >= ticks_i) begin
        level_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q <= '0;
      level_q <= 1'b0;
    end else begin
      integ_q <= integ_d;
      level_q <= level_d;
    end
  end

  assign level_o      = level_q;
  assign level_next_o = level_d;

endmodule

`default_nettype wire

/* rtl/core/ebid_core.sv */
// Button state: raw levels, integrator lanes and sticky event flags.
`default_nettype none

module ebid_core
  import ebid_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            step_i,
  input  item_t           item_i,
  input  logic [CntW-1:0] ticks_i,
  output res_t            res_o
);

  logic [NumButtons-1:0] raw_q, raw_d;
  logic [NumButtons-1:0] press_q, press_d;
  logic [NumButtons-1:0] rel_q, rel_d;
  logic [NumButtons-1:0] sel;
  logic [NumButtons-1:0] lvl;
  logic [NumButtons-1:0] lvl_next;
  logic [NumButtons-1:0] change;
  logic                  tick;

  assign tick = step_i && (item_i.op == OP_TICK);

  for (genvar g = 0; g < NumButtons; g++) begin : g_lane
    assign sel[g] = (item_i.idx == IdxW'(g));

    ebid_lane u_lane (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .tick_i       (tick),
      .raw_i        (raw_q[g]),
      .ticks_i      (ticks_i),
      .level_o      (lvl[g]),
      .level_next_o (lvl_next[g])
    );
  end

  assign change = lvl ^ lvl_next;

  always_comb begin
    raw_d   = raw_q;
    press_d = press_q;
    rel_d   = rel_q;
    if (step_i) begin
      unique case (item_i.op)
        OP_SET: begin
          raw_d = item_i.level ? (raw_q | sel) : (raw_q & ~sel);
        end
        OP_TICK: begin
          press_d = press_q | (lvl_next & change);
          rel_d   = rel_q | (~lvl_next & change);
        end
        OP_CLR_PRESS: begin
          press_d = press_q & ~sel;
        end
        OP_CLR_REL: begin
          rel_d = rel_q & ~sel;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raw_q   <= '0;
      press_q <= '0;
      rel_q   <= '0;
    end else begin
      raw_q   <= raw_d;
      press_q <= press_d;
      rel_q   <= rel_d;
    end
  end

  assign res_o.levels   = lvl_next;
  assign res_o.pressed  = press_d;
  assign res_o.released = rel_d;

endmodule

`default_nettype wire

/* sim/eight_button_integrating_debouncer_test.sv */
// Self-checking testbench for the eight button integrating debouncer.
module eight_button_integrating_debouncer_test;
  import ebid_pkg::*;

  localparam int CycleLimit = 200000;
  localparam int DrainCycles = 6;

  class debounce_tracker;
    logic [CntW-1:0]       period;
    logic [NumButtons-1:0] raw_lvls;
    logic [CntW-1:0]       count [NumButtons];
    logic [NumButtons-1:0] stable_lvls;
    logic [NumButtons-1:0] last_lvls;
    logic [NumButtons-1:0] press_flags;
    logic [NumButtons-1:0] rel_flags;
    res_t                  reports_due [$];
    int                    errors;
    int                    items;
    int                    reports;

    function new();
      int b;
      period = DEBOUNCE_RESET;
      raw_lvls = '0;
      for (b = 0; b < NumButtons; b++) count[b] = '0;
      stable_lvls = '0;
      last_lvls = '0;
      press_flags = '0;
      rel_flags = '0;
      errors = 0;
      items = 0;
      reports = 0;
    endfunction

    function void set_period(logic [CntW-1:0] p);
      period = p;
    endfunction

    function void apply_item(item_t it);
      int b;
      logic [NumButtons-1:0] changed;
      res_t r;
      items++;
      case (it.op)
        OP_SET: raw_lvls[it.idx] = it.level;
        OP_CLR_PRESS: press_flags[it.idx] = 1'b0;
        OP_CLR_REL: rel_flags[it.idx] = 1'b0;
        default: begin
          for (b = 0; b < NumButtons; b++) begin
            if (raw_lvls[b]) begin
              if (count[b] < period) count[b] = count[b] + 1'b1;
              else count[b] = period;
            end else if (count[b] != 0) begin
              count[b] = count[b] - 1'b1;
            end
            if (count[b] == 0) stable_lvls[b] = 1'b0;
            else if (count[b] >= period) stable_lvls[b] = 1'b1;
          end
          changed = last_lvls ^ stable_lvls;
          press_flags |= stable_lvls & changed;
          rel_flags |= ~stable_lvls & changed;
          last_lvls = stable_lvls;
        end
      endcase
      r.levels = stable_lvls;
      r.pressed = press_flags;
      r.released = rel_flags;
      reports_due.push_back(r);
    endfunction

    function void check_report(res_t got);
      res_t want;
      reports++;
      if (reports_due.size() == 0) begin
        $display("%0t: unexpected report levels %h pressed %h released %h",
                 $time, got.levels, got.pressed, got.released);
        errors++;
        return;
      end
      want = reports_due.pop_front();
      if (got.levels !== want.levels) begin
        $display("%0t: debounced levels expected %h actual %h", $time, want.levels, got.levels);
        errors++;
      end
      if (got.pressed !== want.pressed) begin
        $display("%0t: pressed flags expected %h actual %h", $time, want.pressed, got.pressed);
        errors++;
      end
      if (got.released !== want.released) begin
        $display("%0t: released flags expected %h actual %h", $time, want.released,
                 got.released);
        errors++;
      end
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic [1:0]            op_i;
  logic [IdxW-1:0]       button_index_i;
  logic                  raw_level_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  logic [NumButtons-1:0] debounced_levels_o;
  logic [NumButtons-1:0] pressed_flags_o;
  logic [NumButtons-1:0] released_flags_o;
  logic                  cfg_we_i;
  logic [CntW-1:0]       cfg_wdata_i;

  debounce_tracker tracker = new();
  int idle_pct;
  int stall_pct;
  int cycles;
  int periods_used;

  eight_button_integrating_debouncer dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .op_i               (op_i),
    .button_index_i     (button_index_i),
    .raw_level_i        (raw_level_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .debounced_levels_o (debounced_levels_o),
    .pressed_flags_o    (pressed_flags_o),
    .released_flags_o   (released_flags_o),
    .cfg_we_i           (cfg_we_i),
    .cfg_wdata_i        (cfg_wdata_i)
  );

  initial clk_i = 1'b0;
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("eight_button_integrating_debouncer_test failed");
      $finish;
    end
  end

  always @(posedge clk_i) out_stall_i <= ($urandom_range(99) < stall_pct);

  always @(posedge clk_i) begin
    res_t got;
    item_t seen;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        got.levels = debounced_levels_o;
        got.pressed = pressed_flags_o;
        got.released = released_flags_o;
        tracker.check_report(got);
      end
      if (in_valid_i && !in_stall_o) begin
        seen.op = op_e'(op_i);
        seen.idx = button_index_i;
        seen.level = raw_level_i;
        tracker.apply_item(seen);
      end
    end
  end

  task automatic send_item(op_e op, int idx, int level);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i <= op;
    button_index_i <= idx[IdxW-1:0];
    raw_level_i <= level[0];
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic send_random(int tick_pct);
    int pick;
    op_e op;
    pick = $urandom_range(99);
    if (pick < tick_pct) begin
      op = OP_TICK;
    end else begin
      pick = $urandom_range(99);
      if (pick < 60) op = OP_SET;
      else if (pick < 80) op = OP_CLR_PRESS;
      else op = OP_CLR_REL;
    end
    send_item(op, $urandom_range(NumButtons - 1), $urandom_range(1));
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (tracker.reports_due.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_period(logic [CntW-1:0] p);
    drain();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= p;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    tracker.set_period(p);
    periods_used++;
  endtask

  initial begin
    int periods [8];
    int counts [8];
    int ticks [8];
    int ph;
    int n;
    periods = '{255, 2, 1, 0, 7, 3, 4, 0};
    counts = '{450, 150, 120, 100, 180, 150, 150, 150};
    ticks = '{96, 50, 45, 50, 50, 50, 50, 50};
    periods[7] = $urandom_range(1, 12);
    idle_pct = 0;
    stall_pct = 0;
    cycles = 0;
    periods_used = 0;
    rst_ni <= 1'b0;
    in_valid_i <= 1'b0;
    op_i <= OP_SET;
    button_index_i <= '0;
    raw_level_i <= 1'b0;
    out_stall_i <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_wdata_i <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // press the outer buttons, bounce a middle one, release and clear
    send_item(OP_SET, 0, 1);
    send_item(OP_SET, 7, 1);
    repeat (5) send_item(OP_TICK, 5, 1);
    send_item(OP_CLR_PRESS, 0, 1);
    send_item(OP_CLR_REL, 7, 1);
    send_item(OP_SET, 7, 0);
    repeat (5) send_item(OP_TICK, 7, 0);
    send_item(OP_CLR_REL, 7, 0);
    send_item(OP_CLR_PRESS, 7, 0);
    send_item(OP_SET, 3, 1);
    repeat (2) send_item(OP_TICK, 2, 0);
    send_item(OP_SET, 3, 0);
    repeat (2) send_item(OP_TICK, 0, 1);

    for (ph = 0; ph < 8; ph++) begin
      write_period(CntW'(periods[ph]));
      idle_pct = (ph % 4 == 1) ? 80 : (ph % 4 == 3) ? 15 : 0;
      stall_pct = (ph % 4 == 2) ? 80 : (ph % 4 == 3) ? 15 : 0;
      for (n = 0; n < counts[ph]; n++) send_random(ticks[ph]);
    end
    drain();

    $display("run covered %0d items and %0d reports over %0d debounce periods,",
             tracker.items, tracker.reports, periods_used);
    $display("with sender gaps and receiver stalls mixed in across the phases");
    if (tracker.errors == 0 && tracker.reports_due.size() == 0) begin
      $display("eight_button_integrating_debouncer_test passed");
    end else begin
      $display("eight_button_integrating_debouncer_test failed");
    end
    $finish;
  end
endmodule

/* sim.f */
rtl/core/ebid_pkg.sv
rtl/core/ebid_lane.sv
rtl/core/ebid_core.sv
rtl/core/eight_button_integrating_debouncer.sv
sim/eight_button_integrating_debouncer_test.sv
